// ----- src/chd_pkg.sv -----
// ----------------------------------------------------------------------------
// chd_pkg
// Shared types, constants and helpers of the chunked body decoder.
// ----------------------------------------------------------------------------
package chd_pkg;

  localparam int unsigned SIZE_WIDTH_DEF = 32;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned BODY_W         = 32;
  localparam int unsigned SKIP_W         = 2;

  localparam logic [BODY_W-1:0] MAX_BODY_RST = '1;

  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

  // bytes dropped after each chunk's data
  localparam logic [SKIP_W-1:0] CRLF_LEN = 2'd2;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_LIMIT       = 2'd1,
    ERR_CLOSED_LINE = 2'd2,
    ERR_CLOSED_DATA = 2'd3
  } err_e;

  typedef enum logic [6:0] {
    PH_LEAD   = 7'b0000001,
    PH_DIGITS = 7'b0000010,
    PH_REST   = 7'b0000100,
    PH_DATA   = 7'b0001000,
    PH_SKIP   = 7'b0010000,
    PH_DONE   = 7'b0100000,
    PH_HALT   = 7'b1000000
  } phase_e;

  typedef struct packed {
    phase_e              phase;
    logic                prev_cr;
    logic [SKIP_W-1:0]   skip_left;
  } ctrl_t;

  typedef struct packed {
    logic [BYTE_W-1:0] body_byte;
    logic              body_valid;
    logic              finished;
    err_e              error_code;
  } result_t;

  // bit 4: character is a hex digit, bits 3:0: its value
  function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ----- src/chd_step.sv -----
// ----------------------------------------------------------------------------
// chd_step
// Next-state and result logic for one byte of the chunked stream.
// ----------------------------------------------------------------------------
module chd_step #(
  parameter int unsigned SIZE_WIDTH = chd_pkg::SIZE_WIDTH_DEF
) (
  input  logic [chd_pkg::BYTE_W-1:0] data_byte_i,
  input  logic                       connection_closed_i,
  input  chd_pkg::ctrl_t             ctrl_i,
  input  logic [SIZE_WIDTH-1:0]      chunk_i,
  input  logic [chd_pkg::BODY_W-1:0] total_i,
  input  logic [chd_pkg::BODY_W-1:0] max_body_i,
  output chd_pkg::ctrl_t             ctrl_o,
  output logic [SIZE_WIDTH-1:0]      chunk_o,
  output logic [chd_pkg::BODY_W-1:0] total_o,
  output chd_pkg::result_t           res_o
);
  import chd_pkg::*;

  localparam int unsigned CMP_W = (SIZE_WIDTH > BODY_W) ? SIZE_WIDTH : BODY_W;

  logic [4:0]          hex;
  logic [CMP_W-1:0]    size_ext;
  logic [CMP_W-1:0]    headroom;
  logic                over_limit;
  logic [SIZE_WIDTH-1:0] chunk_dec;
  logic [SKIP_W-1:0]   skip_dec;
  logic                lf_after_cr;

  assign hex       = hex_decode(data_byte_i);
  assign size_ext  = CMP_W'(chunk_i);
  assign headroom  = CMP_W'(max_body_i - total_i);
  assign over_limit = (total_i > max_body_i) || (size_ext > headroom);
  assign chunk_dec = chunk_i - SIZE_WIDTH'(1);
  assign skip_dec  = ctrl_i.skip_left - SKIP_W'(1);
  assign lf_after_cr = ctrl_i.prev_cr && (data_byte_i == CH_LF);

  always_comb begin
    ctrl_o  = ctrl_i;
    chunk_o = chunk_i;
    total_o = total_i;
    res_o   = '0;
    res_o.error_code = ERR_NONE;

    if (connection_closed_i) begin
      case (ctrl_i.phase)
        PH_LEAD, PH_DIGITS, PH_REST: begin
          res_o.error_code = ERR_CLOSED_LINE;
          ctrl_o.phase     = PH_HALT;
        end
        PH_DATA, PH_SKIP: begin
          res_o.error_code = ERR_CLOSED_DATA;
          ctrl_o.phase     = PH_HALT;
        end
        default: begin
        end
      endcase
    end else begin
      case (ctrl_i.phase)
        PH_LEAD, PH_DIGITS, PH_REST: begin
          if (lf_after_cr) begin
            ctrl_o.prev_cr = 1'b0;
            if (chunk_i == '0) begin
              ctrl_o.phase = PH_DONE;
            end else if (over_limit) begin
              ctrl_o.phase     = PH_HALT;
              res_o.error_code = ERR_LIMIT;
            end else begin
              total_o          = total_i + size_ext[BODY_W-1:0];
              ctrl_o.phase     = PH_DATA;
              ctrl_o.skip_left = '0;
            end
          end else begin
            if (ctrl_i.phase == PH_LEAD && data_byte_i == CH_SPACE) begin
              ctrl_o.phase = PH_LEAD;
            end else if (ctrl_i.phase != PH_REST && hex[4]) begin
              // saturate once another digit would overflow
              if (|chunk_i[SIZE_WIDTH-1 -: 4]) begin
                chunk_o = '1;
              end else begin
                chunk_o = {chunk_i[SIZE_WIDTH-5:0], hex[3:0]};
              end
              ctrl_o.phase = PH_DIGITS;
            end else begin
              ctrl_o.phase = PH_REST;
            end
            ctrl_o.prev_cr = (data_byte_i == CH_CR);
          end
        end
        PH_DATA: begin
          res_o.body_byte  = data_byte_i;
          res_o.body_valid = 1'b1;
          chunk_o          = chunk_dec;
          if (chunk_dec == '0) begin
            ctrl_o.phase     = PH_SKIP;
            ctrl_o.skip_left = CRLF_LEN;
          end
        end
        PH_SKIP: begin
          ctrl_o.skip_left = skip_dec;
          if (skip_dec == '0) begin
            ctrl_o.phase   = PH_LEAD;
            ctrl_o.prev_cr = 1'b0;
            chunk_o        = '0;
          end
        end
        default: begin
        end
      endcase
    end

    res_o.finished = (ctrl_o.phase == PH_DONE);
  end

endmodule

// ----- src/http_chunked_body_decoder_core.sv -----
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// Decodes a chunked transfer body one byte per transaction.
// ----------------------------------------------------------------------------
//  channel | handshake                    | payload
//  --------+------------------------------+-----------------------------------
//  input   | in_valid_i / in_stall_o      | data_byte_i, connection_closed_i
//  output  | out_valid_o / out_stall_i    | body_byte_o, body_valid_o,
//          |                              | finished_o, error_code_o
//  config  | cfg_valid_i / cfg_ready_o    | cfg_data_i (body length limit)
//
//  one transaction per cycle sustained while out_stall_i is low; each byte
//  passes through the input register, then its result is captured in the
//  result register, at which point the registered out_valid_o rises.
//  reset clears the parser state, the body total and sets the limit to all ones.
//  out_stall_i holds the result register; the input register keeps taking
//  transactions until it is full too, then in_stall_o rises.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core #(
  parameter int unsigned SIZE_WIDTH = chd_pkg::SIZE_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [chd_pkg::BYTE_W-1:0] data_byte_i,
  input  logic                       connection_closed_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [chd_pkg::BYTE_W-1:0] body_byte_o,
  output logic                       body_valid_o,
  output logic                       finished_o,
  output logic [1:0]                 error_code_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [chd_pkg::BODY_W-1:0] cfg_data_i
);
  import chd_pkg::*;

  logic                  s1_valid_q;
  logic [BYTE_W-1:0]     s1_byte_q;
  logic                  s1_closed_q;
  logic                  out_valid_q;
  result_t               res_q, res_d;
  ctrl_t                 ctrl_q, ctrl_d;
  logic [SIZE_WIDTH-1:0] chunk_q, chunk_d;
  logic [BODY_W-1:0]     total_q, total_d;
  logic [BODY_W-1:0]     max_body_q;
  logic                  advance;
  logic                  process;
  logic                  in_take;

  assign advance  = !out_valid_q || !out_stall_i;
  assign process  = s1_valid_q && advance;
  assign in_take  = in_valid_i && !in_stall_o;

  assign in_stall_o   = s1_valid_q && !advance;
  assign out_valid_o  = out_valid_q;
  assign body_byte_o  = res_q.body_byte;
  assign body_valid_o = res_q.body_valid;
  assign finished_o   = res_q.finished;
  assign error_code_o = res_q.error_code;
  assign cfg_ready_o  = 1'b1;

  chd_step #(
    .SIZE_WIDTH(SIZE_WIDTH)
  ) u_step (
    .data_byte_i        (s1_byte_q),
    .connection_closed_i(s1_closed_q),
    .ctrl_i             (ctrl_q),
    .chunk_i            (chunk_q),
    .total_i            (total_q),
    .max_body_i         (max_body_q),
    .ctrl_o             (ctrl_d),
    .chunk_o            (chunk_d),
    .total_o            (total_d),
    .res_o              (res_d)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance || !s1_valid_q) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q   <= data_byte_i;
      s1_closed_q <= connection_closed_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      res_q <= res_d;
    end
  end

  // parser state and limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q.phase     <= PH_LEAD;
      ctrl_q.prev_cr   <= 1'b0;
      ctrl_q.skip_left <= '0;
      chunk_q          <= '0;
      total_q          <= '0;
      max_body_q       <= MAX_BODY_RST;
    end else begin
      if (process) begin
        ctrl_q  <= ctrl_d;
        chunk_q <= chunk_d;
        total_q <= total_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        max_body_q <= cfg_data_i;
      end
    end
  end

`ifndef ASSERT_OFF
  a_body_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && body_valid_o) |-> (error_code_o == ERR_NONE && !finished_o))
    else $error("body byte reported together with error or finish");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !body_valid_o) |-> (body_byte_o == '0))
    else $error("body byte not cleared without body valid");

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_q.phase == PH_DONE) |=> (ctrl_q.phase == PH_DONE))
    else $error("left finished phase");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_q.phase == PH_HALT) |=> (ctrl_q.phase == PH_HALT))
    else $error("left halted phase");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with room in the pipeline");
`endif

endmodule
